/* hdl/smacc_pkg.sv */
package smacc_pkg;

    localparam int MAG_W  = 14;
    localparam int WORD_W = MAG_W + 1;
    localparam int CMD_W  = 7;
    localparam int CNT_W  = $clog2(MAG_W);

    localparam logic [CMD_W-1:0] OP_ADD = 7'h30;
    localparam logic [CMD_W-1:0] OP_SUB = 7'h31;
    localparam logic [CMD_W-1:0] OP_DIV = 7'h32;
    localparam logic [CMD_W-1:0] OP_MUL = 7'h33;
    localparam logic [CMD_W-1:0] OP_RCL = 7'h62;

    localparam logic [MAG_W-1:0] MAG_MAX = 14'h3fff;

    // Bit positions of the result flags in m_tuser.
    localparam int FLG_ERR  = 0;
    localparam int FLG_OVF  = 1;
    localparam int FLG_DZ   = 2;
    localparam int FLG_BAD  = 3;
    localparam int FLG_HALT = 4;
    localparam int FLG_W    = 5;

    typedef struct packed {
        logic start;
        logic is_div;
    } mdu_ctrl_t;

endpackage

/* hdl/smacc_mdu.sv */
module smacc_mdu (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  smacc_pkg::mdu_ctrl_t         ctrl,
    input  logic [smacc_pkg::MAG_W-1:0]  op_a,
    input  logic [smacc_pkg::MAG_W-1:0]  op_b,
    output logic                         done,
    output logic [2*smacc_pkg::MAG_W-1:0] result
);

    localparam int W = smacc_pkg::MAG_W;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [smacc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic               is_div_reg, is_div_next;
    logic [W-1:0]       x_reg, x_next;
    logic [2*W:0]       p_reg, p_next;

    logic [W:0]         add_a;
    logic [W+1:0]       add_res;
    logic [W:0]         upper;
    logic [W:0]         rem;
    logic               fits;

    // One shared adder: multiply adds the multiplicand to the upper half,
    // divide subtracts the divisor from the shifted partial remainder.
    always_comb begin
        add_a   = is_div_reg ? p_reg[2*W-1:W-1] : p_reg[2*W:W];
        add_res = {1'b0, add_a}
                + ({2'b00, x_reg} ^ {(W+2){is_div_reg}})
                + {{(W+1){1'b0}}, is_div_reg};
        upper   = p_reg[0] ? add_res[W:0] : p_reg[2*W:W];
        fits    = ~add_res[W+1];
        rem     = fits ? add_res[W:0] : p_reg[2*W-1:W-1];
    end

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        is_div_next = is_div_reg;
        x_next      = x_reg;
        p_next      = p_reg;
        if (ctrl.start && !busy_reg) begin
            busy_next   = 1'b1;
            cnt_next    = smacc_pkg::CNT_W'(W - 1);
            is_div_next = ctrl.is_div;
            x_next      = ctrl.is_div ? op_b : op_a;
            p_next      = {{(W+1){1'b0}}, ctrl.is_div ? op_a : op_b};
        end else if (busy_reg) begin
            if (is_div_reg) begin
                p_next = {rem, p_reg[W-2:0], fits};
            end else begin
                p_next = {1'b0, upper, p_reg[W-1:1]};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        is_div_reg <= is_div_next;
        x_reg      <= x_next;
        p_reg      <= p_next;
    end

    assign done   = done_reg;
    assign result = p_reg[2*W-1:0];

endmodule

/* hdl/sign_magnitude_accumulator_alu_unit.sv */
// Add, subtract, rotate and every error case register their result, wait in ST_EMIT until
// the output register is free and hand it on; multiply and divide first pass through ST_RUN.
// Multiply and divide run 14 steps through one shared add/subtract unit in smacc_mdu.
// A new instruction is taken only after the last result has reached the output register.
// Reset (synchronous, aresetn low) clears the accumulator, the sequencer, the output valid
// flag and the busy and done flags of smacc_mdu.
module sign_magnitude_accumulator_alu_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // command[6:0], operand_word[21:7], zero pad
    input  logic [0:0]  s_tuser,  // read_failed[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // acc_value[14:0], zero pad
    output logic [4:0]  m_tuser   // error, overflow, divzero, bad_opcode, halt_clock
);

    localparam int W  = smacc_pkg::MAG_W;
    localparam int WW = smacc_pkg::WORD_W;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_t;

    state_t                        state_reg, state_next;
    logic [WW-1:0]                 acc_reg, acc_next;
    logic                          neg_reg, neg_next;
    logic                          div_reg, div_next;
    logic [WW-1:0]                 res_acc_reg, res_acc_next;
    logic [smacc_pkg::FLG_W-1:0]   res_flg_reg, res_flg_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [WW-1:0]                 m_acc_reg, m_acc_next;
    logic [smacc_pkg::FLG_W-1:0]   m_flg_reg, m_flg_next;

    logic [smacc_pkg::CMD_W-1:0]   cmd;
    logic [WW-1:0]                 word;
    logic                          rfail;
    logic                          known;
    logic                          is_sub;
    logic [W+1:0]                  a16, b16, sum16, mag16;
    logic                          add_ovf;
    logic [WW-1:0]                 add_acc;
    logic [WW-1:0]                 rot_acc;
    logic                          b_zero;
    logic                          accept;

    smacc_pkg::mdu_ctrl_t          mdu_ctrl;
    logic                          mdu_done;
    logic [2*W-1:0]                mdu_result;
    logic                          mul_ovf;
    logic [W-1:0]                  mdu_mag;

    assign cmd    = s_tdata[smacc_pkg::CMD_W-1:0];
    assign word   = s_tdata[smacc_pkg::CMD_W+WW-1:smacc_pkg::CMD_W];
    assign rfail  = s_tuser[0];
    assign accept = s_tvalid && s_tready;

    always_comb begin
        case (cmd)
            smacc_pkg::OP_ADD, smacc_pkg::OP_SUB, smacc_pkg::OP_DIV,
            smacc_pkg::OP_MUL, smacc_pkg::OP_RCL: known = 1'b1;
            default:                               known = 1'b0;
        endcase
    end

    // Add and subtract in two's complement; the sum always fits in 16 bits.
    always_comb begin
        is_sub  = (cmd == smacc_pkg::OP_SUB);
        a16     = acc_reg[W] ? (16'd0 - {2'b00, acc_reg[W-1:0]}) : {2'b00, acc_reg[W-1:0]};
        b16     = (word[W] ^ is_sub) ? (16'd0 - {2'b00, word[W-1:0]})
                                     : {2'b00, word[W-1:0]};
        sum16   = a16 + b16;
        mag16   = sum16[W+1] ? (16'd0 - sum16) : sum16;
        add_ovf = mag16 > {2'b00, smacc_pkg::MAG_MAX};
        add_acc = add_ovf ? '0 : {sum16[W+1], mag16[W-1:0]};
        rot_acc = {word[W], word[W-2:0], word[W-1]};
        b_zero  = (word[W-1:0] == '0);
    end

    always_comb begin
        mdu_ctrl.start  = accept && known && !rfail
                       && ((cmd == smacc_pkg::OP_MUL)
                        || (cmd == smacc_pkg::OP_DIV && !b_zero));
        mdu_ctrl.is_div = (cmd == smacc_pkg::OP_DIV);
    end

    smacc_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mdu_ctrl),
        .op_a    (acc_reg[W-1:0]),
        .op_b    (word[W-1:0]),
        .done    (mdu_done),
        .result  (mdu_result)
    );

    assign mul_ovf = !div_reg && (mdu_result[2*W-1:W] != '0);
    assign mdu_mag = mdu_result[W-1:0];

    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        div_next      = div_reg;
        res_acc_next  = res_acc_reg;
        res_flg_next  = res_flg_reg;
        m_tvalid_next = m_tvalid_reg;
        m_acc_next    = m_acc_reg;
        m_flg_next    = m_flg_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_acc_next = acc_reg;
                    res_flg_next = '0;
                    neg_next     = acc_reg[W] ^ word[W];
                    div_next     = (cmd == smacc_pkg::OP_DIV);
                    state_next   = ST_EMIT;
                    if (!known) begin
                        res_flg_next[smacc_pkg::FLG_ERR]  = 1'b1;
                        res_flg_next[smacc_pkg::FLG_BAD]  = 1'b1;
                        res_flg_next[smacc_pkg::FLG_HALT] = 1'b1;
                    end else if (rfail) begin
                        res_flg_next[smacc_pkg::FLG_ERR] = 1'b1;
                    end else begin
                        case (cmd)
                            smacc_pkg::OP_ADD, smacc_pkg::OP_SUB: begin
                                res_acc_next                     = add_acc;
                                res_flg_next[smacc_pkg::FLG_OVF] = add_ovf;
                            end
                            smacc_pkg::OP_RCL: begin
                                res_acc_next = rot_acc;
                            end
                            smacc_pkg::OP_DIV: begin
                                if (b_zero) begin
                                    res_flg_next[smacc_pkg::FLG_ERR] = 1'b1;
                                    res_flg_next[smacc_pkg::FLG_DZ]  = 1'b1;
                                end else begin
                                    state_next = ST_RUN;
                                end
                            end
                            default: begin
                                state_next = ST_RUN;
                            end
                        endcase
                    end
                end
            end
            ST_RUN: begin
                if (mdu_done) begin
                    res_flg_next                     = '0;
                    res_flg_next[smacc_pkg::FLG_OVF] = mul_ovf;
                    // A zero magnitude is always stored with a positive sign.
                    res_acc_next = mul_ovf ? '0
                                 : {neg_reg && (mdu_mag != '0), mdu_mag};
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_acc_next    = res_acc_reg;
                    m_flg_next    = res_flg_reg;
                    acc_next      = res_acc_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        neg_reg     <= neg_next;
        div_reg     <= div_next;
        res_acc_reg <= res_acc_next;
        res_flg_reg <= res_flg_next;
        m_acc_reg   <= m_acc_next;
        m_flg_reg   <= m_flg_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_acc_reg};
    assign m_tuser  = m_flg_reg;

    // The accumulator only moves when a result is handed to the output register.
    a_acc_only_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && acc_reg != $past(acc_reg)) |-> $past(state_reg == ST_EMIT))
        else $error("accumulator changed outside result hand-off");

    a_mdu_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        mdu_done |-> state_reg == ST_RUN)
        else $error("multiply/divide unit finished while not running");

    a_ovf_clears_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_flg_reg[smacc_pkg::FLG_OVF]) |-> m_acc_reg == '0)
        else $error("overflow result with nonzero accumulator");

    a_bad_implies_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_flg_reg[smacc_pkg::FLG_BAD])
            |-> (m_flg_reg[smacc_pkg::FLG_ERR] && m_flg_reg[smacc_pkg::FLG_HALT]))
        else $error("bad opcode without error and halt flags");

endmodule
